// File: hw/rtl/tlb_page_table_translator_core_defines.svh
// ----------------------------------------------------------------------------
// assertion macros shared by the tlb translator rtl
// ----------------------------------------------------------------------------
`ifndef TLB_PAGE_TABLE_TRANSLATOR_CORE_DEFINES_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_CORE_DEFINES_SVH

// same-cycle implication, checked at every rising edge outside reset
`define TLBPT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked at every rising edge outside reset
`define TLBPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/tlbpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlbpt_pkg
// sizes, entry types and helpers shared by the tlb translator modules
// ----------------------------------------------------------------------------
package tlbpt_pkg;

   // geometry
   localparam int TLB_DEPTH   = 16;
   localparam int PAGE_COUNT  = 256;
   localparam int FRAME_TOTAL = 256;
   localparam int PAGE_BYTES  = 256;

   // derived widths
   localparam int ADDR_W   = 16;
   localparam int COUNT_W  = 32;
   localparam int OFFSET_W = $clog2(PAGE_BYTES);
   localparam int PAGE_W   = $clog2(PAGE_COUNT);
   localparam int FRAME_W  = $clog2(FRAME_TOTAL);
   localparam int FREE_W   = $clog2(FRAME_TOTAL + 1);

   // one tlb entry as it moves down the cell row
   typedef struct packed {
      logic               valid;
      logic [PAGE_W-1:0]  tag;
      logic [FRAME_W-1:0] frame;
   } tlbpt_entry_type;

   // fill request from the controller into the head of the row
   typedef struct packed {
      logic            shift;
      tlbpt_entry_type entry;
   } tlbpt_fill_type;

   // lookup result from the row back to the controller
   typedef struct packed {
      logic               hit;
      logic [FRAME_W-1:0] frame;
   } tlbpt_lookup_type;

   // saturating increment of a running count
   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      sat_inc = (v == {COUNT_W{1'b1}}) ? v : v + 1'b1;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/tlbpt_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlbpt channel interfaces
// valid/ready channels for the address request and the translation response
// ----------------------------------------------------------------------------
interface tlbpt_req_if;
   import tlbpt_pkg::*;

   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] virt_addr;

   modport source (output valid, output virt_addr, input ready);
   modport sink   (input valid, input virt_addr, output ready);
endinterface

interface tlbpt_rsp_if;
   import tlbpt_pkg::*;

   logic               valid;
   logic               ready;
   logic [ADDR_W-1:0]  phys_addr;
   logic               tlb_hit;
   logic               page_fault;
   logic               frames_exhausted;
   logic [COUNT_W-1:0] address_count;
   logic [COUNT_W-1:0] fault_count;
   logic [COUNT_W-1:0] hit_count;

   modport source (output valid, output phys_addr, output tlb_hit,
                   output page_fault, output frames_exhausted, output address_count,
                   output fault_count, output hit_count, input ready);
   modport sink   (input valid, input phys_addr, input tlb_hit,
                   input page_fault, input frames_exhausted, input address_count,
                   input fault_count, input hit_count, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/tlbpt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlbpt_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module tlbpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: hw/rtl/tlbpt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlbpt_cell
// one tlb entry: holds tag and frame, compares its tag, passes its entry on
// ----------------------------------------------------------------------------
module tlbpt_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      shift,
   input  tlbpt_pkg::tlbpt_entry_type prev_entry,
   input  logic [tlbpt_pkg::PAGE_W-1:0] page,
   output tlbpt_pkg::tlbpt_entry_type entry,
   output logic                      match
);
   import tlbpt_pkg::*;

   logic               valid_ff;
   logic [PAGE_W-1:0]  tag_ff;
   logic [FRAME_W-1:0] frame_ff;

   // valid bit, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= prev_entry.valid;
      end
   end

   // tag and frame payload, taken from the upstream neighbor on a shift
   always_ff @(posedge clock) begin
      if (shift) begin
         tag_ff   <= prev_entry.tag;
         frame_ff <= prev_entry.frame;
      end
   end

   // local tag compare
   assign match = valid_ff && (tag_ff == page);

   assign entry.valid = valid_ff;
   assign entry.tag   = tag_ff;
   assign entry.frame = frame_ff;

endmodule
`default_nettype wire

// File: hw/rtl/tlbpt_tlb.sv
`timescale 1ns / 1ps
`default_nettype none
`include "tlb_page_table_translator_core_defines.svh"
// ----------------------------------------------------------------------------
// tlbpt_tlb
// fully associative tlb built as a shifting row of cells; new entries enter
// at the head and the oldest entry drops off the tail, giving fifo refill
// ----------------------------------------------------------------------------
module tlbpt_tlb (
   input  logic                         clock,
   input  logic                         reset,
   input  tlbpt_pkg::tlbpt_fill_type    fill,
   input  logic [tlbpt_pkg::PAGE_W-1:0] page,
   output tlbpt_pkg::tlbpt_lookup_type  lookup
);
   import tlbpt_pkg::*;

   tlbpt_entry_type      entry_w [TLB_DEPTH];
   logic [TLB_DEPTH-1:0] match_w;
   logic [FRAME_W-1:0]   frame_w;

   // row of cells, each fed by its upstream neighbor
   for (genvar i = 0; i < TLB_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         tlbpt_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .shift      (fill.shift),
            .prev_entry (fill.entry),
            .page       (page),
            .entry      (entry_w[i]),
            .match      (match_w[i])
         );
      end else begin : g_body
         tlbpt_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .shift      (fill.shift),
            .prev_entry (entry_w[i-1]),
            .page       (page),
            .entry      (entry_w[i]),
            .match      (match_w[i])
         );
      end
   end

   // merge the frame of the matching cell, at most one matches
   always_comb begin
      frame_w = '0;
      for (int i = 0; i < TLB_DEPTH; i++) begin
         frame_w = frame_w | (match_w[i] ? entry_w[i].frame : '0);
      end
   end

   assign lookup.hit   = |match_w;
   assign lookup.frame = frame_w;

   // a page is only ever filled after a miss, so it lives in one cell at most
   `TLBPT_ASSERT_SAME(a_single_match, clock, reset, 1'b1, $onehot0(match_w), "tlb page in two cells")

endmodule
`default_nettype wire

// File: hw/rtl/tlb_page_table_translator_core.sv
`timescale 1ns / 1ps
`default_nettype none
`include "tlb_page_table_translator_core_defines.svh"
// ----------------------------------------------------------------------------
// tlb_page_table_translator_core
// Logical to physical address translator with a 16-entry fifo-refilled tlb
// and a demand-paged page table. Each address passes through two states: in
// S_IDLE the accept issues the page-table ram read, S_RESOLVE does the tlb
// compare, resolves hit, page-table lookup or frame allocation, writes back
// the page table and tlb, and loads the response register. The registered
// read of the page-table ram is why resolve is a state of its own; the block
// takes one address at a time, and S_RESOLVE waits while an earlier response
// is still held on rsp. Page-table valid bits are flip-flops cleared by reset,
// so no clearing pass is needed. When all frames are used a faulting address
// gets frames_exhausted and leaves every piece of state untouched.
// ----------------------------------------------------------------------------
module tlb_page_table_translator_core (
   input  logic         clock,
   input  logic         reset,
   tlbpt_req_if.sink    req,
   tlbpt_rsp_if.source  rsp
);
   import tlbpt_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE    = 2'b01,
      S_RESOLVE = 2'b10
   } tlbpt_state_type;

   tlbpt_state_type state_ff, state_in;

   logic [PAGE_W-1:0]    page_ff;
   logic [OFFSET_W-1:0]  offset_ff;
   logic [PAGE_COUNT-1:0] pm_valid_ff;
   logic [FREE_W-1:0]    free_ptr_ff, free_ptr_in;
   logic [COUNT_W-1:0]   translated_ff, translated_in;
   logic [COUNT_W-1:0]   faults_ff, faults_in;
   logic [COUNT_W-1:0]   hits_ff, hits_in;

   logic                 rsp_valid_ff;
   logic [ADDR_W-1:0]    rsp_phys_ff;
   logic                 rsp_hit_ff;
   logic                 rsp_fault_ff;
   logic                 rsp_exhaust_ff;
   logic [COUNT_W-1:0]   rsp_translated_ff;
   logic [COUNT_W-1:0]   rsp_faults_ff;
   logic [COUNT_W-1:0]   rsp_hits_ff;

   logic                 accept;
   logic                 fire;
   logic [PAGE_W-1:0]    req_page;
   logic [FRAME_W-1:0]   pm_frame;
   logic                 pm_valid;
   logic                 miss;
   logic                 fault;
   logic                 exhaust;
   logic                 alloc;
   logic [FRAME_W-1:0]   frame_sel;
   logic [ADDR_W-1:0]    phys;
   tlbpt_fill_type       fill;
   tlbpt_lookup_type     lookup;

   // input handshake and page split
   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;
   assign req_page  = PAGE_W'(req.virt_addr >> OFFSET_W);

   // resolve completes once the response register is free
   assign fire = (state_ff == S_RESOLVE) && (!rsp_valid_ff || rsp.ready);

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_RESOLVE;
            end
         end
         S_RESOLVE: begin
            if (fire) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // capture the transaction's page and offset
   always_ff @(posedge clock) begin
      if (accept) begin
         page_ff   <= req_page;
         offset_ff <= req.virt_addr[OFFSET_W-1:0];
      end
   end

   // page-table frame store, read on accept, written on allocation
   tlbpt_ram #(
      .WIDTH (FRAME_W),
      .DEPTH (PAGE_COUNT)
   ) u_page_map (
      .clock   (clock),
      .wr_en   (fire && alloc),
      .wr_addr (page_ff),
      .wr_data (frame_sel),
      .rd_en   (accept),
      .rd_addr (req_page),
      .rd_data (pm_frame)
   );

   // tlb row
   tlbpt_tlb u_tlb (
      .clock  (clock),
      .reset  (reset),
      .fill   (fill),
      .page   (page_ff),
      .lookup (lookup)
   );

   // resolve: hit, page-table hit, allocation or exhaustion
   assign pm_valid  = pm_valid_ff[page_ff];
   assign miss      = !lookup.hit;
   assign fault     = miss && !pm_valid;
   assign exhaust   = fault && (free_ptr_ff >= FREE_W'(FRAME_TOTAL));
   assign alloc     = fault && !exhaust;

   always_comb begin
      priority if (lookup.hit) begin
         frame_sel = lookup.frame;
      end else if (pm_valid) begin
         frame_sel = pm_frame;
      end else begin
         frame_sel = free_ptr_ff[FRAME_W-1:0];
      end
   end

   assign phys = ADDR_W'({frame_sel, offset_ff});

   // refill the tlb head after any miss that got a frame
   assign fill.shift       = fire && miss && !exhaust;
   assign fill.entry.valid = 1'b1;
   assign fill.entry.tag   = page_ff;
   assign fill.entry.frame = frame_sel;

   // page-table valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         pm_valid_ff <= '0;
      end else if (fire && alloc) begin
         pm_valid_ff[page_ff] <= 1'b1;
      end
   end

   // next free frame and running totals
   always_comb begin
      free_ptr_in   = free_ptr_ff;
      translated_in = translated_ff;
      faults_in     = faults_ff;
      hits_in       = hits_ff;
      if (alloc) begin
         free_ptr_in = free_ptr_ff + 1'b1;
         faults_in   = sat_inc(faults_ff);
      end
      if (lookup.hit) begin
         hits_in = sat_inc(hits_ff);
      end
      if (!exhaust) begin
         translated_in = sat_inc(translated_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ptr_ff   <= '0;
         translated_ff <= '0;
         faults_ff     <= '0;
         hits_ff       <= '0;
      end else if (fire) begin
         free_ptr_ff   <= free_ptr_in;
         translated_ff <= translated_in;
         faults_ff     <= faults_in;
         hits_ff       <= hits_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_phys_ff       <= exhaust ? '0 : phys;
         rsp_hit_ff        <= lookup.hit;
         rsp_fault_ff      <= alloc;
         rsp_exhaust_ff    <= exhaust;
         rsp_translated_ff <= translated_in;
         rsp_faults_ff     <= faults_in;
         rsp_hits_ff       <= hits_in;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.phys_addr        = rsp_phys_ff;
   assign rsp.tlb_hit          = rsp_hit_ff;
   assign rsp.page_fault       = rsp_fault_ff;
   assign rsp.frames_exhausted = rsp_exhaust_ff;
   assign rsp.address_count    = rsp_translated_ff;
   assign rsp.fault_count      = rsp_faults_ff;
   assign rsp.hit_count        = rsp_hits_ff;

   // checks
   `TLBPT_ASSERT_SAME(a_free_ptr_range, clock, reset, 1'b1,
      free_ptr_ff <= FREE_W'(FRAME_TOTAL), "free frame pointer past frame total")
   `TLBPT_ASSERT_NEXT(a_alloc_step, clock, reset, fire && alloc,
      free_ptr_ff == $past(free_ptr_ff) + 1'b1, "allocation did not advance free pointer")
   `TLBPT_ASSERT_NEXT(a_exhaust_frozen, clock, reset, fire && exhaust,
      $stable(translated_ff) && $stable(free_ptr_ff) && $stable(pm_valid_ff),
      "state changed on exhausted frames")
   `TLBPT_ASSERT_SAME(a_rsp_flags, clock, reset, rsp_valid_ff,
      !(rsp_hit_ff && rsp_fault_ff) && !(rsp_exhaust_ff && (rsp_hit_ff || rsp_fault_ff)),
      "conflicting response flags")

endmodule
`default_nettype wire

// File: tb/tlb_page_table_translator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_page_table_translator_core_tb
// Self-checking bench for the tlb / page-table translator. A directed table
// walks fault, hit, fifo eviction and table-walk cases. Random addresses then
// follow, half drawn from a working set of recent pages. Every accepted
// address runs through a local translation model. Responses are compared
// field by field against the queued predictions. Both channels idle in
// random bursts.
// ----------------------------------------------------------------------------
module tlb_page_table_translator_core_tb;
   import tlbpt_pkg::*;

   localparam int RAND_ITEMS     = 1750;
   localparam int QUIET_TAIL     = 250;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RECENT_DEPTH   = 32;
   localparam int DIR_ROWS       = 24;

   // one translation as seen on the response channel
   typedef struct packed {
      logic [ADDR_W-1:0]  phys;
      logic               hit;
      logic               fault;
      logic               exhausted;
      logic [COUNT_W-1:0] addr_cnt;
      logic [COUNT_W-1:0] fault_cnt;
      logic [COUNT_W-1:0] hit_cnt;
   } xlate_type;

   // directed row: address plus an optional hand-typed expected translation
   typedef struct {
      logic [ADDR_W-1:0] addr;
      bit                typed;
      xlate_type         exp;
   } dir_row_type;

   logic clock;
   logic reset;

   tlbpt_req_if req_bus ();
   tlbpt_rsp_if rsp_bus ();

   tlb_page_table_translator_core u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // translation model state
   logic [PAGE_W-1:0]  tlb_tag_m   [TLB_DEPTH];
   logic [FRAME_W-1:0] tlb_frame_m [TLB_DEPTH];
   bit                 tlb_vld_m   [TLB_DEPTH];
   logic [FRAME_W-1:0] pmap_frame_m [PAGE_COUNT];
   bit                 pmap_vld_m   [PAGE_COUNT];
   int                 free_frame_m;
   int                 fill_slot;
   logic [COUNT_W-1:0] addr_total;
   logic [COUNT_W-1:0] fault_total;
   logic [COUNT_W-1:0] hit_total;

   xlate_type         pending_translations[$];
   logic [PAGE_W-1:0] recent_pages[$];

   int  error_count;
   int  seen_hits;
   int  seen_faults;
   int  seen_walks;
   int  seen_exhausted;
   int  checked_count;
   int  idle_cycles;
   bit  idle_on;
   int  stall_left;

   // directed table; the typed rows are the opening fault/hit pattern
   dir_row_type dir_table [DIR_ROWS] = '{
      // first touch of page 0 faults into frame 0
      '{16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b1, 1'b0, 32'd1, 32'd1, 32'd0}},
      // same page, top offset: tlb hit
      '{16'h00FF, 1'b1, '{16'h00FF, 1'b1, 1'b0, 1'b0, 32'd2, 32'd1, 32'd1}},
      // top page, top offset faults into frame 1
      '{16'hFFFF, 1'b1, '{16'h01FF, 1'b0, 1'b1, 1'b0, 32'd3, 32'd2, 32'd1}},
      '{16'hFF00, 1'b1, '{16'h0100, 1'b1, 1'b0, 1'b0, 32'd4, 32'd2, 32'd2}},
      '{16'h8001, 1'b1, '{16'h0201, 1'b0, 1'b1, 1'b0, 32'd5, 32'd3, 32'd2}},
      '{16'h7FFE, 1'b1, '{16'h03FE, 1'b0, 1'b1, 1'b0, 32'd6, 32'd4, 32'd2}},
      // fill the tlb, then two more pages evict the oldest entries
      '{16'h0110, 1'b0, '0}, '{16'h0221, 1'b0, '0}, '{16'h0332, 1'b0, '0},
      '{16'h0443, 1'b0, '0}, '{16'h0554, 1'b0, '0}, '{16'h0665, 1'b0, '0},
      '{16'h0776, 1'b0, '0}, '{16'h0887, 1'b0, '0}, '{16'h0998, 1'b0, '0},
      '{16'h0AA9, 1'b0, '0}, '{16'h0BBA, 1'b0, '0}, '{16'h0CCB, 1'b0, '0},
      '{16'h0DDC, 1'b0, '0}, '{16'h0EED, 1'b0, '0},
      // evicted pages come back through the page table without a fault
      '{16'h0000, 1'b0, '0}, '{16'hFF80, 1'b0, '0},
      // alternating bit patterns
      '{16'h5555, 1'b0, '0}, '{16'hAAAA, 1'b0, '0}
   };

   // saturating bump of a running total
   function automatic logic [COUNT_W-1:0] bump_total(input logic [COUNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // clear the model to its post-reset state
   function automatic void clear_model();
      for (int i = 0; i < TLB_DEPTH; i++) begin
         tlb_vld_m[i]   = 1'b0;
         tlb_tag_m[i]   = '0;
         tlb_frame_m[i] = '0;
      end
      for (int p = 0; p < PAGE_COUNT; p++) begin
         pmap_vld_m[p]   = 1'b0;
         pmap_frame_m[p] = '0;
      end
      free_frame_m = 0;
      fill_slot    = 0;
      addr_total   = '0;
      fault_total  = '0;
      hit_total    = '0;
   endfunction

   // translate one address and advance the model state
   function automatic xlate_type predict_translation(input logic [ADDR_W-1:0] addr);
      xlate_type            r;
      logic [PAGE_W-1:0]    page;
      logic [OFFSET_W-1:0]  offset;
      logic [FRAME_W-1:0]   frame;
      bit                   hit;
      bit                   fault;
      r      = '0;
      page   = PAGE_W'(addr >> OFFSET_W);
      offset = addr[OFFSET_W-1:0];
      frame  = '0;
      hit    = 1'b0;
      fault  = 1'b0;

      // associative lookup, lowest index wins
      for (int i = 0; i < TLB_DEPTH; i++) begin
         if (!hit && tlb_vld_m[i] && tlb_tag_m[i] == page) begin
            hit   = 1'b1;
            frame = tlb_frame_m[i];
         end
      end

      if (!hit) begin
         if (pmap_vld_m[page]) begin
            frame = pmap_frame_m[page];
         end else if (free_frame_m >= FRAME_TOTAL) begin
            // no frame left: flag it, leave every piece of state alone
            r.exhausted = 1'b1;
            r.addr_cnt  = addr_total;
            r.fault_cnt = fault_total;
            r.hit_cnt   = hit_total;
            return r;
         end else begin
            fault              = 1'b1;
            frame              = FRAME_W'(free_frame_m);
            free_frame_m       = free_frame_m + 1;
            pmap_frame_m[page] = frame;
            pmap_vld_m[page]   = 1'b1;
            fault_total        = bump_total(fault_total);
         end
         // fifo refill of the tlb
         tlb_tag_m[fill_slot]   = page;
         tlb_frame_m[fill_slot] = frame;
         tlb_vld_m[fill_slot]   = 1'b1;
         fill_slot              = (fill_slot + 1) % TLB_DEPTH;
      end else begin
         hit_total = bump_total(hit_total);
      end
      addr_total = bump_total(addr_total);

      r.phys      = ADDR_W'(32'(frame) * PAGE_BYTES + 32'(offset));
      r.hit       = hit;
      r.fault     = fault;
      r.addr_cnt  = addr_total;
      r.fault_cnt = fault_total;
      r.hit_cnt   = hit_total;
      return r;
   endfunction

   // random address: recent pages half the time, else fresh pages, edge offsets or edge pages
   function automatic logic [ADDR_W-1:0] pick_address();
      logic [PAGE_W-1:0]   page;
      logic [OFFSET_W-1:0] offset;
      int                  pick;
      pick   = $urandom_range(0, 9);
      page   = PAGE_W'($urandom);
      offset = OFFSET_W'($urandom);
      if (pick <= 4 && recent_pages.size() != 0) begin
         page = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
      end else if (pick == 8) begin
         offset = $urandom_range(0, 1) ? '1 : '0;
      end else if (pick == 9) begin
         page = $urandom_range(0, 1) ? '1 : '0;
      end
      return {page, offset};
   endfunction

   // drive one address transaction, holding valid across back-to-back items
   task automatic send_item(input logic [ADDR_W-1:0] addr, input bit typed,
                            input xlate_type typed_exp);
      int        gap;
      xlate_type pred;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_bus.valid     <= 1'b0;
         req_bus.virt_addr <= ADDR_W'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.virt_addr <= addr;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);

      // transaction accepted at this edge
      pred = predict_translation(addr);
      pending_translations.push_back(typed ? typed_exp : pred);
      recent_pages.push_back(PAGE_W'(addr >> OFFSET_W));
      if (recent_pages.size() > RECENT_DEPTH) void'(recent_pages.pop_front());
      if (pred.exhausted)  seen_exhausted++;
      else if (pred.hit)   seen_hits++;
      else if (pred.fault) seen_faults++;
      else                 seen_walks++;
   endtask

   // one field compare with a report on mismatch
   function automatic void check_field(input string fld, input logic [COUNT_W-1:0] exp_v,
                                       input logic [COUNT_W-1:0] act_v);
      if (exp_v !== act_v) begin
         error_count++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fld, exp_v, act_v);
      end
   endfunction

   // response side: random stall bursts, none in the quiet tail
   initial begin
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left != 0) begin
            stall_left--;
         end else if (idle_on && !reset && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 8);
         end
         rsp_bus.ready <= (stall_left == 0);
      end
   end

   // response checker
   always @(posedge clock) begin
      xlate_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_translations.size() == 0) begin
            error_count++;
            $display("%0t: response with nothing expected, actual phys 0x%0h",
                     $time, rsp_bus.phys_addr);
         end else begin
            want = pending_translations.pop_front();
            checked_count++;
            check_field("phys_addr", COUNT_W'(want.phys),
                        COUNT_W'(rsp_bus.phys_addr));
            check_field("tlb_hit", COUNT_W'(want.hit), COUNT_W'(rsp_bus.tlb_hit));
            check_field("page_fault", COUNT_W'(want.fault), COUNT_W'(rsp_bus.page_fault));
            check_field("frames_exhausted", COUNT_W'(want.exhausted),
                        COUNT_W'(rsp_bus.frames_exhausted));
            check_field("address_count", want.addr_cnt, rsp_bus.address_count);
            check_field("fault_count", want.fault_cnt, rsp_bus.fault_count);
            check_field("hit_count", want.hit_cnt, rsp_bus.hit_count);
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d translations outstanding",
                  $time, pending_translations.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // main sequence
   initial begin
      error_count    = 0;
      checked_count  = 0;
      seen_hits      = 0;
      seen_faults    = 0;
      seen_walks     = 0;
      seen_exhausted = 0;
      idle_cycles    = 0;
      idle_on        = 1'b1;
      reset          = 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.virt_addr <= '0;
      clear_model();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int r = 0; r < DIR_ROWS; r++) begin
         send_item(dir_table[r].addr, dir_table[r].typed, dir_table[r].exp);
      end

      // random traffic, no idling in the tail
      for (int n = 0; n < RAND_ITEMS; n++) begin
         idle_on = (n < RAND_ITEMS - QUIET_TAIL);
         send_item(pick_address(), 1'b0, '0);
      end
      req_bus.valid <= 1'b0;

      // drain
      while (pending_translations.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      // frames run out only once every page is mapped, so no address
      // can fault into an empty pool with this geometry
      $display("checked %0d translations: %0d tlb hits, %0d page faults, %0d table walks",
               checked_count, seen_hits, seen_faults, seen_walks);
      $display("pages mapped %0d of %0d, exhausted responses %0d, errors %0d",
               free_frame_m, PAGE_COUNT, seen_exhausted, error_count);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/tlbpt_pkg.sv
hw/rtl/tlbpt_if.sv
hw/rtl/tlbpt_ram.sv
hw/rtl/tlbpt_cell.sv
hw/rtl/tlbpt_tlb.sv
hw/rtl/tlb_page_table_translator_core.sv
tb/tlb_page_table_translator_core_tb.sv
